[src/ajb_pkg.sv]
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared types and constants of the speaker jitter buffer with rate feedback.
// ----------------------------------------------------------------------------
`default_nettype none

package ajb_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int HALF_WORDS_DEF  = 32;

    localparam int CNT_W      = 32;
    localparam int RATE_W     = 20;
    localparam int NOM_W      = 17;
    localparam int THR_W      = 17;
    localparam int PERIOD_W   = 8;
    localparam int SAMPLE_W   = 16;
    localparam int FB_W       = 24;
    localparam int ADDR_W_MAX = 13;

    localparam logic [NOM_W-1:0]  NOM_RESET   = NOM_W'(16000);
    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(16000);
    localparam logic [RATE_W-1:0] RATE_MAX    = {RATE_W{1'b1}};
    localparam logic [CNT_W-1:0]  RENORM_LIM  = 32'h2000_0000;
    localparam logic [CNT_W-1:0]  RENORM_STEP = 32'h1000_0000;
    localparam int                STEP_SHIFT  = 10;

    // r / 1000 as (r * RECIP) >> RECIP_SH, exact for r < 2^20
    localparam logic [20:0] RECIP    = 21'd1073742;
    localparam int          RECIP_SH = 30;
    localparam logic [9:0]  KHZ_DIV  = 10'd1000;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_PREFILL  = 3'd1,
        ST_UNDERRUN = 3'd2,
        ST_FAULT    = 3'd3,
        ST_FEEDBACK = 3'd4
    } status_t;

    // one queued request for the back end
    typedef struct packed {
        status_t               status;
        logic [ADDR_W_MAX-1:0] base;
        logic [ADDR_W_MAX:0]   hw;
        logic [RATE_W-1:0]     rate;
    } cmd_t;

endpackage

`default_nettype wire

[src/ajb_ram.sv]
// ----------------------------------------------------------------------------
// ajb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/ajb_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// ajb_cmd_fifo
// Two-entry request queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ajb_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output ajb_pkg::cmd_t      head,
    output logic               not_empty,
    output logic               full
);
    import ajb_pkg::*;

    cmd_t       slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign head      = slot_reg[rp_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_cmd;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[src/ajb_front.sv]
// ----------------------------------------------------------------------------
// ajb_front
// Accepts requests, runs the ring bookkeeping, stage rules and rate control,
// writes samples into the store and queues read and query work.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_front #(
    parameter int STORE_DEPTH = ajb_pkg::STORE_DEPTH_DEF,
    parameter int HALF_WORDS  = ajb_pkg::HALF_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [ajb_pkg::SAMPLE_W-1:0]  sample_in,
    input  wire logic                          packet_start,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ajb_pkg::NOM_W-1:0]     cfg_data,
    input  wire logic                          q_full,
    input  wire logic                          q_not_empty,
    input  wire logic                          back_busy,
    output logic                               q_push,
    output ajb_pkg::cmd_t                      q_cmd,
    output logic                               wr_en,
    output logic [$clog2(STORE_DEPTH)-1:0]     wr_addr,
    output logic [ajb_pkg::SAMPLE_W-1:0]       wr_data
);
    import ajb_pkg::*;

    localparam int AW       = $clog2(STORE_DEPTH);
    localparam int WRAP_END = ((STORE_DEPTH - 1) / HALF_WORDS) * HALF_WORDS;
    localparam logic [AW:0]        WRAP_V   = (AW+1)'(WRAP_END);
    localparam logic [AW:0]        HALF_A   = (AW+1)'(HALF_WORDS);
    localparam logic [CNT_W-1:0]   HALF_C   = CNT_W'(HALF_WORDS);
    localparam logic [CNT_W-1:0]   PRE_LVL  = CNT_W'(STORE_DEPTH / 2);
    localparam logic [CNT_W:0]     DEPTH_C  = (CNT_W+1)'(STORE_DEPTH);
    localparam logic [THR_W-1:0]   THR_INIT = THR_W'(STORE_DEPTH / 2);
    localparam logic signed [17:0] HALF_S   = 18'(HALF_WORDS);
    localparam logic signed [17:0] THR_MAXS = 18'sd65535;
    localparam logic signed [17:0] THR_MINS = -18'sd65536;

    typedef enum logic [1:0] {
        STG_RESTART = 2'd0,
        STG_PREFILL = 2'd1,
        STG_RUN     = 2'd2
    } stage_t;

    stage_t             stage_reg,  stage_next;
    logic [AW-1:0]      wi_reg,     wi_next;
    logic [AW-1:0]      ri_reg,     ri_next;
    logic [AW:0]        hw_reg,     hw_next;
    logic [CNT_W-1:0]   wcnt_reg,   wcnt_next;
    logic [CNT_W-1:0]   rcnt_reg,   rcnt_next;
    logic [THR_W-1:0]   thr_reg,    thr_next;
    logic [PERIOD_W-1:0] per_reg,   per_next;
    logic [RATE_W-1:0]  rate_reg,   rate_next;
    logic [NOM_W-1:0]   nom_reg,    nom_next;
    logic               fault_reg,  fault_next;
    logic               adj_reg,    adj_next;

    logic               acc;
    logic               ready;
    logic [AW-1:0]      wi_eff;
    logic [CNT_W-1:0]   wcnt_eff;
    logic [AW:0]        wi_inc;
    logic [AW:0]        ri_inc;
    logic signed [CNT_W:0] delta;
    logic signed [17:0] thr_s;
    logic signed [17:0] thr_lo;
    logic signed [17:0] thr_hi;
    logic [RATE_W:0]    rate_up;
    logic [RATE_W-1:0]  step;

    // writes wait while any request is queued or the back end is still issuing one
    always_comb
    begin
        ready = !adj_reg && !q_full;
        if (kind_t'(kind) == KIND_WRITE && (q_not_empty || back_busy))
        begin
            ready = 1'b0;
        end
    end

    assign in_stall  = !ready;
    assign acc       = in_valid && ready;
    assign cfg_ready = 1'b1;

    // shared arithmetic
    assign wi_inc  = {1'b0, wi_eff} + (AW+1)'(1);
    assign ri_inc  = {1'b0, ri_reg} + HALF_A;
    assign delta   = $signed({1'b0, wcnt_reg}) - $signed({1'b0, rcnt_reg});
    assign thr_s   = 18'(signed'(thr_reg));
    assign thr_lo  = thr_s - HALF_S;
    assign thr_hi  = thr_s + HALF_S;
    assign step    = RATE_W'(nom_reg >> STEP_SHIFT);
    assign rate_up = {1'b0, rate_reg} + {1'b0, step};

    always_comb
    begin
        stage_next = stage_reg;
        wi_next    = wi_reg;
        ri_next    = ri_reg;
        hw_next    = hw_reg;
        wcnt_next  = wcnt_reg;
        rcnt_next  = rcnt_reg;
        thr_next   = thr_reg;
        per_next   = per_reg;
        rate_next  = rate_reg;
        nom_next   = nom_reg;
        fault_next = fault_reg;
        adj_next   = 1'b0;
        wi_eff     = wi_reg;
        wcnt_eff   = wcnt_reg;
        q_push     = 1'b0;
        q_cmd.status = ST_DATA;
        q_cmd.base   = ADDR_W_MAX'(ri_reg);
        q_cmd.hw     = (ADDR_W_MAX+1)'(hw_reg);
        q_cmd.rate   = rate_reg;
        wr_en      = 1'b0;

        // deferred level check after every period of reads
        if (adj_reg)
        begin
            if (delta < (CNT_W+1)'(thr_lo))
            begin
                thr_next  = (thr_lo < THR_MINS) ? THR_W'(THR_MINS) : THR_W'(thr_lo);
                rate_next = rate_up[RATE_W] ? RATE_MAX : rate_up[RATE_W-1:0];
            end
            else if (delta > (CNT_W+1)'(thr_hi))
            begin
                thr_next  = (thr_hi > THR_MAXS) ? THR_W'(THR_MAXS) : THR_W'(thr_hi);
                rate_next = (rate_reg < step) ? '0 : rate_reg - step;
            end
            if (rcnt_reg > RENORM_LIM)
            begin
                rcnt_next = rcnt_reg - RENORM_STEP;
                wcnt_next = wcnt_reg - RENORM_STEP;
            end
        end

        if (acc)
        begin
            unique case (kind_t'(kind))
                KIND_WRITE:
                begin
                    if (!fault_reg)
                    begin
                        if (packet_start)
                        begin
                            unique case (stage_reg)
                                STG_RESTART:
                                begin
                                    wi_eff     = '0;
                                    wcnt_eff   = '0;
                                    ri_next    = '0;
                                    rcnt_next  = '0;
                                    stage_next = STG_PREFILL;
                                    thr_next   = THR_INIT;
                                end
                                STG_PREFILL:
                                begin
                                    if (wcnt_reg >= PRE_LVL)
                                    begin
                                        stage_next = STG_RUN;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        wr_en     = 1'b1;
                        wi_next   = (wi_inc >= WRAP_V) ? '0 : wi_inc[AW-1:0];
                        wcnt_next = wcnt_eff + CNT_W'(1);
                        if (wi_inc > hw_reg)
                        begin
                            hw_next = wi_inc;
                        end
                    end
                end
                KIND_READ:
                begin
                    q_push = 1'b1;
                    if (fault_reg)
                    begin
                        q_cmd.status = ST_FAULT;
                    end
                    else if (stage_reg == STG_RESTART || stage_reg == STG_PREFILL)
                    begin
                        q_cmd.status = ST_PREFILL;
                    end
                    else if ({1'b0, wcnt_reg} >= {1'b0, rcnt_reg} + DEPTH_C)
                    begin
                        q_cmd.status = ST_FAULT;
                        fault_next   = 1'b1;
                    end
                    else if (rcnt_reg >= wcnt_reg)
                    begin
                        q_cmd.status = ST_UNDERRUN;
                        stage_next   = STG_RESTART;
                        wi_next      = '0;
                        ri_next      = '0;
                        wcnt_next    = '0;
                        rcnt_next    = '0;
                    end
                    else
                    begin
                        q_cmd.status = ST_DATA;
                        ri_next   = (ri_inc >= WRAP_V) ? '0 : ri_inc[AW-1:0];
                        rcnt_next = rcnt_reg + HALF_C;
                        per_next  = per_reg + PERIOD_W'(1);
                        adj_next  = (per_reg == {PERIOD_W{1'b1}});
                    end
                end
                KIND_QUERY:
                begin
                    q_push       = 1'b1;
                    q_cmd.status = ST_FEEDBACK;
                end
                KIND_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // nominal rate write also reloads the live rate
        if (cfg_valid)
        begin
            nom_next  = cfg_data;
            rate_next = RATE_W'(cfg_data);
        end
    end

    assign wr_addr = wi_eff;
    assign wr_data = sample_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STG_RESTART;
            wi_reg    <= '0;
            ri_reg    <= '0;
            hw_reg    <= '0;
            wcnt_reg  <= '0;
            rcnt_reg  <= '0;
            thr_reg   <= '0;
            per_reg   <= '0;
            rate_reg  <= RATE_RESET;
            nom_reg   <= NOM_RESET;
            fault_reg <= 1'b0;
            adj_reg   <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            wi_reg    <= wi_next;
            ri_reg    <= ri_next;
            hw_reg    <= hw_next;
            wcnt_reg  <= wcnt_next;
            rcnt_reg  <= rcnt_next;
            thr_reg   <= thr_next;
            per_reg   <= per_next;
            rate_reg  <= rate_next;
            nom_reg   <= nom_next;
            fault_reg <= fault_next;
            adj_reg   <= adj_next;
        end
    end

endmodule

`default_nettype wire

[src/ajb_back.sv]
// ----------------------------------------------------------------------------
// ajb_back
// Carries out queued requests: streams half buffers from the store or
// silence, and formats feedback replies, behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_back #(
    parameter int STORE_DEPTH = ajb_pkg::STORE_DEPTH_DEF,
    parameter int HALF_WORDS  = ajb_pkg::HALF_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    input  wire ajb_pkg::cmd_t                 q_head,
    output logic                               q_pop,
    output logic                               busy,
    output logic                               rd_en,
    output logic [$clog2(STORE_DEPTH)-1:0]     rd_addr,
    input  wire logic [ajb_pkg::SAMPLE_W-1:0]  rd_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ajb_pkg::SAMPLE_W-1:0]       sample_out,
    output logic                               last,
    output logic [2:0]                         status,
    output logic [ajb_pkg::FB_W-1:0]           rate_fb
);
    import ajb_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int KW = (HALF_WORDS > 1) ? $clog2(HALF_WORDS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(HALF_WORDS - 1);

    logic              act_reg;
    cmd_t              cur_reg;
    logic [KW-1:0]     cnt_reg;
    logic [10:0]       q_reg;

    logic              pend_vld_reg;
    logic              pend_ram_reg;
    logic              pend_last_reg;
    status_t           pend_st_reg;
    logic [FB_W-1:0]   pend_fb_reg;

    logic              out_vld_reg;
    logic [SAMPLE_W-1:0] out_s_reg;
    logic              out_last_reg;
    status_t           out_st_reg;
    logic [FB_W-1:0]   out_fb_reg;

    logic              out_ok;
    logic              pend_ld;
    logic              issue;
    logic              load;
    logic              is_fb;
    logic              g_last;
    logic              use_ram;
    logic [AW:0]       addr;
    logic [40:0]       prod;
    logic [20:0]       q_mul;
    logic [9:0]        rem;
    logic [FB_W-1:0]   fb;

    assign out_ok  = !out_vld_reg || !out_stall;
    assign pend_ld = !pend_vld_reg || out_ok;
    assign issue   = act_reg && pend_ld;
    assign load    = !act_reg && q_not_empty;
    assign q_pop   = load;
    assign busy    = act_reg;

    // rate / 1000 by reciprocal, registered before the remainder
    assign prod  = {21'b0, q_head.rate} * {20'b0, RECIP};
    assign q_mul = {10'b0, q_reg} * {11'b0, KHZ_DIV};
    assign rem   = 10'(cur_reg.rate - q_mul[RATE_W-1:0]);
    assign fb    = {q_reg[9:0], rem, 4'b0};

    // next result word
    assign is_fb   = (cur_reg.status == ST_FEEDBACK);
    assign g_last  = is_fb || (cnt_reg == K_LAST);
    assign addr    = (AW+1)'(cur_reg.base) + (AW+1)'(cnt_reg);
    assign use_ram = (cur_reg.status == ST_DATA) && (addr < (AW+1)'(cur_reg.hw));
    assign rd_en   = issue && use_ram;
    assign rd_addr = addr[AW-1:0];

    assign out_valid  = out_vld_reg;
    assign sample_out = out_s_reg;
    assign last       = out_last_reg;
    assign status     = out_st_reg;
    assign rate_fb    = out_fb_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_head;
            q_reg   <= prod[RECIP_SH+10:RECIP_SH];
        end
        if (issue)
        begin
            pend_ram_reg  <= use_ram;
            pend_last_reg <= g_last;
            pend_st_reg   <= cur_reg.status;
            pend_fb_reg   <= is_fb ? fb : '0;
        end
        if (out_ok && pend_vld_reg)
        begin
            out_s_reg    <= pend_ram_reg ? rd_data : '0;
            out_last_reg <= pend_last_reg;
            out_st_reg   <= pend_st_reg;
            out_fb_reg   <= pend_fb_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= 1'b0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                act_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + KW'(1);
                if (g_last)
                begin
                    act_reg <= 1'b0;
                end
            end
            if (pend_ld)
            begin
                pend_vld_reg <= issue;
            end
            if (out_ok)
            begin
                out_vld_reg <= pend_vld_reg;
            end
        end
    end

endmodule

`default_nettype wire

[src/audio_jitter_buffer_rate_feedback_core.sv]
// ----------------------------------------------------------------------------
// audio_jitter_buffer_rate_feedback_core
// Speaker jitter buffer with asynchronous rate feedback.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): kind selects a sample write, a
//   half-buffer read request or a feedback query. Writes give no result.
//   A read gives HALF_WORDS results (data, prefill silence, underrun or
//   fault silence), a query gives one result: kHz in bits 23:14, remainder
//   Hz in bits 13:4. Output channel (out_valid / out_stall): one result per
//   cycle unless stalled, last marks the final result of a request.
//   Config channel (cfg_valid / cfg_ready): writes the nominal rate and
//   reloads the live rate; always ready; written only while idle by rule:
//   the user must see to it, the block does not enforce it. A read streams
//   one word per cycle unless stalled, bounded by the single store read port.
//   A write is held off while any queued read or query is still pending;
//   the cycle after every 256th data read is spent on the level check.
//   Reset clears the ring state, rate 16000 Hz, no clearing pass: store words
//   never written since reset read as zero through a high-water mark.
//   When the receiver stalls, results hold and the two-entry request queue
//   fills, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_jitter_buffer_rate_feedback_core #(
    parameter int STORE_DEPTH = ajb_pkg::STORE_DEPTH_DEF,
    parameter int HALF_WORDS  = ajb_pkg::HALF_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [ajb_pkg::SAMPLE_W-1:0]  sample_in,
    input  wire logic                          packet_start,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ajb_pkg::SAMPLE_W-1:0]       sample_out,
    output logic                               last,
    output logic [2:0]                         status,
    output logic [ajb_pkg::FB_W-1:0]           rate_fb,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ajb_pkg::NOM_W-1:0]     cfg_data
);
    import ajb_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic               q_push;
    cmd_t               q_cmd;
    logic               q_pop;
    cmd_t               q_head;
    logic               q_not_empty;
    logic               q_full;
    logic               back_busy;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    ajb_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .HALF_WORDS  (HALF_WORDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .sample_in    (sample_in),
        .packet_start (packet_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_not_empty  (q_not_empty),
        .back_busy    (back_busy),
        .q_push       (q_push),
        .q_cmd        (q_cmd),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    ajb_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    ajb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ajb_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .HALF_WORDS  (HALF_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .busy        (back_busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .last        (last),
        .status      (status),
        .rate_fb     (rate_fb)
    );

    // a sample write never lands while the store is being fetched
    a_no_write_during_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en |-> !rd_en))
        else $error("store written during a read fetch");

    // a feedback reply is always a single, final result
    a_fb_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FEEDBACK) |-> last)
        else $error("feedback reply without last");

    // only data results carry samples, only replies carry a rate
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_DATA || sample_out == '0) &&
                       (status == ST_FEEDBACK || rate_fb == '0)))
        else $error("field set for wrong status");

    // the queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("request queue overflow");

endmodule

`default_nettype wire

[bench/audio_jitter_buffer_rate_feedback_core_tb.sv]
// ----------------------------------------------------------------------------
// audio_jitter_buffer_rate_feedback_core_tb
// Drives sample writes, half-buffer reads and feedback queries into the jitter
// buffer under random handshake pressure, predicts every result from an
// internal behavioral copy of the buffer, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module audio_jitter_buffer_rate_feedback_core_tb;
    import ajb_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int HALF      = 32;
    localparam int WRAP      = ((DEPTH - 1) / HALF) * HALF;
    localparam int THR_HI    = 65535;
    localparam int THR_LO    = -65536;
    localparam int CYCLE_LIM = 400000;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
        logic [2:0]  status;
        logic [23:0] fb;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [15:0] sample_in;
    logic        packet_start;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] sample_out;
    logic        last;
    logic [2:0]  status;
    logic [23:0] rate_fb;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    // predictor state
    logic [15:0]    ring [DEPTH];
    int unsigned    wr_idx, rd_idx, wr_cnt, rd_cnt, stage, period_cnt;
    int unsigned    rate_hz, nominal_hz;
    int             threshold;
    bit             fault;
    result_t        pending_results[$];

    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    audio_jitter_buffer_rate_feedback_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .sample_in(sample_in), .packet_start(packet_start),
        .out_valid(out_valid), .out_stall(out_stall),
        .sample_out(sample_out), .last(last), .status(status),
        .rate_fb(rate_fb),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIM)
        begin
            $display("** audio_jitter_buffer_rate_feedback_core: FAILED **");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    function automatic int clamp_thr(input int t);
        if (t > THR_HI) return THR_HI;
        if (t < THR_LO) return THR_LO;
        return t;
    endfunction

    task automatic push_silence(input status_t st);
        result_t r;
        for (int k = 0; k < HALF; k++)
        begin
            r = '{sample: 16'h0, last: (k == HALF - 1), status: st, fb: 24'h0};
            pending_results.push_back(r);
        end
    endtask

    task automatic reset_model();
        for (int i = 0; i < DEPTH; i++) ring[i] = '0;
        wr_idx = 0; rd_idx = 0; wr_cnt = 0; rd_cnt = 0;
        stage = 0; threshold = 0; period_cnt = 0;
        nominal_hz = 16000; rate_hz = 16000; fault = 0;
    endtask

    // level check every 256 data reads
    task automatic check_level();
        longint     fill;
        int unsigned step;
        fill = longint'(wr_cnt) - longint'(rd_cnt);
        step = nominal_hz / 1024;
        if (fill < longint'(threshold) - HALF)
        begin
            threshold = clamp_thr(threshold - HALF);
            rate_hz = (rate_hz + step > 32'hFFFFF) ? 32'hFFFFF : rate_hz + step;
        end
        else if (fill > longint'(threshold) + HALF)
        begin
            threshold = clamp_thr(threshold + HALF);
            rate_hz = (rate_hz < step) ? 0 : rate_hz - step;
        end
        if (rd_cnt > 32'h2000_0000)
        begin
            rd_cnt -= 32'h1000_0000;
            wr_cnt -= 32'h1000_0000;
        end
    endtask

    // predict the results of one request
    task automatic predict_request(input kind_t k, input logic [15:0] w, input bit pkt);
        result_t r;
        case (k)
            KIND_WRITE:
            begin
                if (!fault)
                begin
                    if (pkt && stage == 0)
                    begin
                        wr_idx = 0; rd_idx = 0; wr_cnt = 0; rd_cnt = 0;
                        stage = 1;
                        threshold = clamp_thr(DEPTH / 2);
                    end
                    else if (pkt && stage == 1 && wr_cnt >= DEPTH / 2)
                        stage = 2;
                    ring[wr_idx] = w;
                    wr_idx++;
                    if (wr_idx >= WRAP) wr_idx = 0;
                    wr_cnt++;
                end
            end
            KIND_READ:
            begin
                if (fault)
                    push_silence(ST_FAULT);
                else if (stage < 2)
                    push_silence(ST_PREFILL);
                else if (longint'(wr_cnt) >= longint'(rd_cnt) + DEPTH)
                begin
                    fault = 1;
                    push_silence(ST_FAULT);
                end
                else if (rd_cnt >= wr_cnt)
                begin
                    stage = 0;
                    wr_idx = 0; rd_idx = 0; wr_cnt = 0; rd_cnt = 0;
                    push_silence(ST_UNDERRUN);
                end
                else
                begin
                    for (int i = 0; i < HALF; i++)
                    begin
                        r = '{sample: ring[rd_idx + i], last: (i == HALF - 1),
                              status: ST_DATA, fb: 24'h0};
                        pending_results.push_back(r);
                    end
                    rd_idx += HALF;
                    rd_cnt += HALF;
                    if (rd_idx >= WRAP) rd_idx = 0;
                    period_cnt = (period_cnt + 1) & 8'hFF;
                    if (period_cnt == 0) check_level();
                end
            end
            KIND_QUERY:
            begin
                r = '{sample: 16'h0, last: 1'b1, status: ST_FEEDBACK,
                      fb: 24'(((rate_hz / 1000) << 14) | ((rate_hz % 1000) << 4))};
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // send one request; drives at falling edge, accepted at rising edge
    task automatic send_request(input kind_t k, input logic [15:0] w, input bit pkt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        kind         = k;
        sample_in    = w;
        packet_start = pkt;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(k, w, pkt);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", {13'h0, status, sample_out}, 32'h0);
            else
            begin
                exp = pending_results.pop_front();
                if (sample_out !== exp.sample)
                    report("sample_out", 32'(sample_out), 32'(exp.sample));
                if (last !== exp.last)
                    report("last", 32'(last), 32'(exp.last));
                if (status !== exp.status)
                    report("status", 32'(status), 32'(exp.status));
                if (rate_fb !== exp.fb)
                    report("rate_fb", 32'(rate_fb), 32'(exp.fb));
            end
        end
    end

    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_nominal(input logic [16:0] hz);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= hz;
        do
            @(posedge clk);
        while (!cfg_ready);
        nominal_hz = 32'(hz);
        rate_hz    = 32'(hz);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mixed stream: a packet-start write, then random writes, reads and queries
    task automatic fill_and_play(input int n_items, input int write_bias);
        int r;
        send_request(KIND_WRITE, 16'($urandom), 1'b1);
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(99);
            if (r < write_bias)
                send_request(KIND_WRITE, 16'($urandom), ($urandom_range(15) == 0));
            else if (r < 97)
                send_request(KIND_READ, 16'($urandom), 1'($urandom));
            else if (r < 99)
                send_request(KIND_QUERY, 16'($urandom), 1'($urandom));
            else
                send_request(KIND_NONE, 16'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_directed();
        send_request(KIND_QUERY, 16'h0, 1'b1);
        send_request(KIND_READ, 16'hFFFF, 1'b1);
        send_request(KIND_NONE, 16'hFFFF, 1'b1);
        send_request(KIND_WRITE, 16'hFFFF, 1'b0);
        send_request(KIND_WRITE, 16'h0000, 1'b1);
        send_request(KIND_WRITE, 16'hFFFF, 1'b0);
        send_request(KIND_READ, 16'h0, 1'b0);
        send_request(KIND_QUERY, 16'hFFFF, 1'b0);
    endtask

    // prefill up to the run stage, then play a few half buffers
    task automatic test_prefill_run();
        send_request(KIND_WRITE, 16'h1234, 1'b1);
        for (int i = 0; i < DEPTH / 2 + 1; i++)
            send_request(KIND_WRITE, 16'($urandom), (i == DEPTH / 2));
        for (int i = 0; i < 6; i++)
            send_request(KIND_READ, 16'h0, 1'b0);
        send_request(KIND_QUERY, 16'h0, 1'b0);
    endtask

    // reads outpace writes here, so the ring runs dry and restarts
    task automatic test_random();
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 31 : (p == 1) ? 73 : 0;
            recv_idle_pct = (p == 0) ? 73 : (p == 1) ? 31 : 0;
            fill_and_play(14, 30);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0; kind = KIND_WRITE; sample_in = '0; packet_start = 1'b0;
        out_stall = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
        errors = 0; cycles = 0;
        send_idle_pct = 31; recv_idle_pct = 73;
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        write_nominal(17'd8000);
        test_prefill_run();
        test_random();
        write_nominal(17'h1FFFF);
        send_request(KIND_QUERY, 16'h0, 1'b0);
        write_nominal(17'd96000);
        send_request(KIND_QUERY, 16'h0, 1'b0);
        write_nominal(17'd1023);
        send_request(KIND_QUERY, 16'h0, 1'b0);
        drain();

        if (errors == 0)
            $display("** audio_jitter_buffer_rate_feedback_core: PASSED **");
        else
            $display("** audio_jitter_buffer_rate_feedback_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/ajb_pkg.sv
src/ajb_ram.sv
src/ajb_cmd_fifo.sv
src/ajb_front.sv
src/ajb_back.sv
src/audio_jitter_buffer_rate_feedback_core.sv
bench/audio_jitter_buffer_rate_feedback_core_tb.sv
